// ===== rtl/fmk_pkg.sv =====
// Shared constants, types and the exponent table of the fuzzy membership kernel.
`default_nettype none
package fmk_pkg;

    localparam int NUM_W       = 6;   // weight outputs
    localparam int MAX_CLS_DEF = 6;
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 16;
    localparam int CNT_W       = 3;
    localparam int Y_W         = 18;  // gain-corrected intensity
    localparam int SQ_W        = 2 * Y_W;
    localparam int EXP_BITS    = 20;  // exponent t, unsigned Q4.16
    localparam int T_SH        = 2 * FRAC_BITS - 8;
    localparam int D_W         = 33;  // affinity, Q1.32
    localparam int SUM_W       = 35;
    localparam int M_SH        = 24;  // membership Q1.24
    localparam int Q_W         = M_SH + 1;
    localparam int N_W         = D_W + M_SH + 1;
    localparam int R_W         = SUM_W + 1;
    localparam int W_SH        = 48 - FRAC_BITS;
    localparam int ADDR_W      = 5;

    // register indexes
    localparam logic [2:0] REG_CLASS_COUNT = 3'd0;
    localparam logic [2:0] REG_SPREAD      = 3'd1;
    localparam logic [2:0] REG_CENTER_0    = 3'd2;

    // exp(-2^j) in Q0.32, j = -16 .. 3
    localparam logic [31:0] EXP_TBL [EXP_BITS] = '{
        32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
        32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
        32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
    };

    typedef struct packed {
        logic [CNT_W-1:0]              class_count;
        logic [DATA_W-1:0]             spread;
        logic [NUM_W-1:0][DATA_W-1:0]  center;
    } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/fmk_cfg.sv =====
// APB register file of the fuzzy membership kernel.
`default_nettype none
module fmk_cfg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fmk_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output fmk_pkg::cfg_t                    cfg
);
    import fmk_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.class_count <= CNT_W'(3);
            cfg_reg.spread      <= 16'd16384;
            cfg_reg.center[0]   <= 16'd0;
            cfg_reg.center[1]   <= 16'd16384;
            cfg_reg.center[2]   <= 16'd32768;
            cfg_reg.center[3]   <= 16'd49152;
            cfg_reg.center[4]   <= 16'd0;
            cfg_reg.center[5]   <= 16'd0;
        end else if (wr) begin
            case (idx)
                REG_CLASS_COUNT: cfg_reg.class_count <= pwdata[CNT_W-1:0];
                REG_SPREAD:      cfg_reg.spread      <= pwdata[DATA_W-1:0];
                default:         cfg_reg.center[idx - REG_CENTER_0] <= pwdata[DATA_W-1:0];
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CLASS_COUNT: prdata = {29'd0, cfg_reg.class_count};
            REG_SPREAD:      prdata = {16'd0, cfg_reg.spread};
            default:         prdata = {16'd0, cfg_reg.center[idx - REG_CENTER_0]};
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/fmk_affinity.sv =====
// Affinity pipeline: gain, distance, exponent, then one exp-table multiply per stage.
`default_nettype none
module fmk_affinity #(
    parameter int NUM_LANES = fmk_pkg::MAX_CLS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_v,
    input  wire logic [fmk_pkg::DATA_W-1:0]    x,
    input  wire logic [fmk_pkg::DATA_W-1:0]    g,
    input  wire fmk_pkg::cfg_t                 cfg,
    output logic                               out_v,
    output logic [fmk_pkg::D_W-1:0]            d [NUM_LANES]
);
    import fmk_pkg::*;

    logic [32:0]     yprod;
    logic [Y_W-1:0]  y_reg;
    logic            v1_reg, v2_reg, v3_reg;
    logic [Y_W-1:0]  diff_reg [NUM_LANES];
    logic [SQ_W-1:0] sq_reg   [NUM_LANES];

    logic            e_v   [EXP_BITS+1];
    logic            e_one [EXP_BITS+1][NUM_LANES];
    logic            e_z   [EXP_BITS+1][NUM_LANES];
    logic [31:0]     e_d   [EXP_BITS+1][NUM_LANES];
    logic [EXP_BITS-1:0] e_t [EXP_BITS+1][NUM_LANES];

    assign yprod = {1'b0, 32'(x) * 32'(g)} + 33'd8192;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            e_v[0] <= 1'b0;
        end else if (en) begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            e_v[0] <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= yprod[Y_W+13:14];
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        logic [Y_W-1:0]         yc;
        logic [SQ_W+DATA_W:0]   tsum;

        assign yc   = Y_W'(cfg.center[i]);
        assign tsum = (SQ_W+DATA_W+1)'(sq_reg[i]) * (SQ_W+DATA_W+1)'(cfg.spread)
                    + ((SQ_W+DATA_W+1)'(1) << (T_SH - 1));

        always_ff @(posedge aclk) begin
            if (en) begin
                diff_reg[i] <= (y_reg >= yc) ? y_reg - yc : yc - y_reg;
                sq_reg[i]   <= SQ_W'(diff_reg[i]) * SQ_W'(diff_reg[i]);
                e_t[0][i]   <= tsum[T_SH+EXP_BITS-1:T_SH];
                e_z[0][i]   <= |tsum[SQ_W+DATA_W:T_SH+EXP_BITS];
                e_one[0][i] <= 1'b1;
                e_d[0][i]   <= 32'd0;
            end
        end

        assign d[i] = e_z[EXP_BITS][i]   ? D_W'(0) :
                      e_one[EXP_BITS][i] ? (D_W'(1) << 32) :
                      D_W'(e_d[EXP_BITS][i]);
    end

    for (genvar j = 0; j < EXP_BITS; j++) begin : g_exp
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                e_v[j+1] <= 1'b0;
            end else if (en) begin
                e_v[j+1] <= e_v[j];
            end
        end

        for (genvar i = 0; i < NUM_LANES; i++) begin : g_el
            logic [63:0] prod;
            assign prod = 64'(e_d[j][i]) * 64'(EXP_TBL[j]) + 64'h8000_0000;

            always_ff @(posedge aclk) begin
                if (en) begin
                    e_t[j+1][i] <= e_t[j][i];
                    e_z[j+1][i] <= e_z[j][i];
                    if (e_t[j][i][j]) begin
                        e_one[j+1][i] <= 1'b0;
                        e_d[j+1][i]   <= e_one[j][i] ? EXP_TBL[j] : prod[63:32];
                    end else begin
                        e_one[j+1][i] <= e_one[j][i];
                        e_d[j+1][i]   <= e_d[j][i];
                    end
                end
            end
        end
    end

    assign out_v = e_v[EXP_BITS];

endmodule
`default_nettype wire

// ===== rtl/fmk_norm.sv =====
// Normalization pipeline: sum, bit-per-stage divide, square and saturate.
`default_nettype none
module fmk_norm #(
    parameter int NUM_LANES = fmk_pkg::MAX_CLS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_v,
    input  wire logic [fmk_pkg::D_W-1:0]     d [NUM_LANES],
    input  wire logic [NUM_LANES-1:0]        act,
    input  wire logic [NUM_LANES-1:0]        last,
    output logic                             out_v,
    output logic [fmk_pkg::DATA_W-1:0]       w [NUM_LANES],
    output logic                             uf
);
    import fmk_pkg::*;

    logic [SUM_W-1:0] sum_c;
    logic [D_W-1:0]   a_d_reg [NUM_LANES];
    logic [SUM_W-1:0] a_sum_reg;
    logic             a_v_reg;

    logic             s_v   [Q_W+1];
    logic             s_uf  [Q_W+1];
    logic [SUM_W-1:0] s_sum [Q_W+1];
    logic [R_W-1:0]   s_r   [Q_W+1][NUM_LANES];
    logic [Q_W-1:0]   s_nl  [Q_W+1][NUM_LANES];
    logic [Q_W-1:0]   s_q   [Q_W+1][NUM_LANES];

    logic             o_v_reg, o_uf_reg;
    logic [DATA_W-1:0] o_w_reg [NUM_LANES];

    always_comb begin
        sum_c = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            sum_c = sum_c + (act[i] ? SUM_W'(d[i]) : SUM_W'(0));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            s_v[0]  <= 1'b0;
            o_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= in_v;
            s_v[0]  <= a_v_reg;
            o_v_reg <= s_v[Q_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_sum_reg <= sum_c;
            s_sum[0]  <= a_sum_reg;
            s_uf[0]   <= (a_sum_reg == '0);
            o_uf_reg  <= s_uf[Q_W];
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        logic [N_W-1:0]      num;
        logic [2*Q_W:0]      sq;

        assign num = N_W'({a_d_reg[i], M_SH'(0)}) + N_W'(a_sum_reg >> 1);
        assign sq  = (2*Q_W+1)'(s_q[Q_W][i]) * (2*Q_W+1)'(s_q[Q_W][i])
                   + ((2*Q_W+1)'(1) << (W_SH - 1));

        always_ff @(posedge aclk) begin
            if (en) begin
                a_d_reg[i]  <= act[i] ? d[i] : D_W'(0);
                s_r[0][i]   <= R_W'(num[N_W-1:Q_W]);
                s_nl[0][i]  <= num[Q_W-1:0];
                s_q[0][i]   <= '0;
                if (s_uf[Q_W]) begin
                    o_w_reg[i] <= last[i] ? {DATA_W{1'b1}} : DATA_W'(0);
                end else if (|sq[2*Q_W:W_SH+DATA_W]) begin
                    o_w_reg[i] <= {DATA_W{1'b1}};
                end else begin
                    o_w_reg[i] <= sq[W_SH+DATA_W-1:W_SH];
                end
            end
        end

        assign w[i] = o_w_reg[i];
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                s_v[k+1] <= 1'b0;
            end else if (en) begin
                s_v[k+1] <= s_v[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_sum[k+1] <= s_sum[k];
                s_uf[k+1]  <= s_uf[k];
            end
        end

        for (genvar i = 0; i < NUM_LANES; i++) begin : g_dl
            logic [R_W-1:0] r2;
            assign r2 = {s_r[k][i][R_W-2:0], s_nl[k][i][Q_W-1-k]};

            always_ff @(posedge aclk) begin
                if (en) begin
                    s_nl[k+1][i] <= s_nl[k][i];
                    if (r2 >= R_W'(s_sum[k])) begin
                        s_r[k+1][i] <= r2 - R_W'(s_sum[k]);
                        s_q[k+1][i] <= s_q[k][i] | (Q_W'(1) << (Q_W - 1 - k));
                    end else begin
                        s_r[k+1][i] <= r2;
                        s_q[k+1][i] <= s_q[k][i];
                    end
                end
            end
        end
    end

    assign out_v = o_v_reg;
    assign uf    = o_uf_reg;

endmodule
`default_nettype wire

// ===== rtl/fuzzy_membership_kernel.sv =====
// Top level of the fuzzy membership kernel: registers, pipelines and output skid.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_voxel_value, s_bias_gain
//  m_        out        m_valid / m_ready    m_weight_0..5, m_all_underflow
//  apb       in         psel/penable/pready  paddr, pwdata, prdata
//
// One voxel per cycle while the skid slot is empty; from accept to m_valid the voxel
// passes through 4 distance stages, 20 exp-table multiply stages, sum, divide setup,
// 25 one-bit divide stages, square stage and the output register.
// Reset (aresetn low, synchronous) clears all valid bits and loads register defaults.
// The whole pipeline holds only while the skid slot is full; a transaction
// is accepted while the output result waits.
`default_nettype none
module fuzzy_membership_kernel #(
    parameter int MAX_CLASSES = fmk_pkg::MAX_CLS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [fmk_pkg::DATA_W-1:0]  s_voxel_value,
    input  wire logic [fmk_pkg::DATA_W-1:0]  s_bias_gain,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [fmk_pkg::DATA_W-1:0]       m_weight_0,
    output logic [fmk_pkg::DATA_W-1:0]       m_weight_1,
    output logic [fmk_pkg::DATA_W-1:0]       m_weight_2,
    output logic [fmk_pkg::DATA_W-1:0]       m_weight_3,
    output logic [fmk_pkg::DATA_W-1:0]       m_weight_4,
    output logic [fmk_pkg::DATA_W-1:0]       m_weight_5,
    output logic                             m_all_underflow,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fmk_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import fmk_pkg::*;

    localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_CLASSES);

    cfg_t                    cfg;
    logic                    en;
    logic [CNT_W-1:0]        n_cls;
    logic [MAX_CLASSES-1:0]  act, last;
    logic                    aff_v, pipe_v, pipe_uf;
    logic [D_W-1:0]          aff_d  [MAX_CLASSES];
    logic [DATA_W-1:0]       pipe_w [MAX_CLASSES];
    logic [DATA_W-1:0]       res_w  [NUM_W];

    // output register plus one skid slot
    logic                    m_valid_reg, skid_v_reg, m_uf_reg, skid_uf_reg;
    logic [DATA_W-1:0]       m_w_reg [NUM_W];
    logic [DATA_W-1:0]       skid_w_reg [NUM_W];

    fmk_cfg u_cfg (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    // clamp the class count into 2..MAX_CLASSES
    always_comb begin
        if (cfg.class_count < CNT_W'(2)) begin
            n_cls = CNT_W'(2);
        end else if (cfg.class_count > MAXC) begin
            n_cls = MAXC;
        end else begin
            n_cls = cfg.class_count;
        end
        for (int i = 0; i < MAX_CLASSES; i++) begin
            act[i]  = CNT_W'(i) < n_cls;
            last[i] = CNT_W'(i) == n_cls - CNT_W'(1);
        end
    end

    assign en      = !skid_v_reg;
    assign s_ready = en;

    fmk_affinity #(.NUM_LANES(MAX_CLASSES)) u_aff (
        .aclk, .aresetn, .en,
        .in_v  (s_valid && s_ready),
        .x     (s_voxel_value),
        .g     (s_bias_gain),
        .cfg,
        .out_v (aff_v),
        .d     (aff_d)
    );

    fmk_norm #(.NUM_LANES(MAX_CLASSES)) u_norm (
        .aclk, .aresetn, .en,
        .in_v  (aff_v),
        .d     (aff_d),
        .act,
        .last,
        .out_v (pipe_v),
        .w     (pipe_w),
        .uf    (pipe_uf)
    );

    // lanes at and above MAX_CLASSES read as zero
    for (genvar i = 0; i < NUM_W; i++) begin : g_res
        if (i < MAX_CLASSES) begin : g_on
            assign res_w[i] = pipe_w[i];
        end else begin : g_off
            assign res_w[i] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            skid_v_reg  <= 1'b0;
        end else if (skid_v_reg) begin
            if (m_ready) begin
                skid_v_reg <= 1'b0;
            end
        end else if (pipe_v) begin
            if (m_valid_reg && !m_ready) begin
                skid_v_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (m_ready) begin
                m_w_reg  <= skid_w_reg;
                m_uf_reg <= skid_uf_reg;
            end
        end else if (pipe_v) begin
            if (m_valid_reg && !m_ready) begin
                skid_w_reg  <= res_w;
                skid_uf_reg <= pipe_uf;
            end else begin
                m_w_reg  <= res_w;
                m_uf_reg <= pipe_uf;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_weight_0      = m_w_reg[0];
    assign m_weight_1      = m_w_reg[1];
    assign m_weight_2      = m_w_reg[2];
    assign m_weight_3      = m_w_reg[3];
    assign m_weight_4      = m_w_reg[4];
    assign m_weight_5      = m_w_reg[5];
    assign m_all_underflow = m_uf_reg;

    // the skid slot only fills behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> m_valid_reg)
        else $error("skid slot full with empty output");

    // a full skid slot with a stalled sink keeps the pipeline frozen
    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg && !m_ready |=> skid_v_reg && !s_ready)
        else $error("skid slot lost a transaction");

    // forced result has exactly one nonzero weight
    a_uf_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_uf_reg |-> $onehot({m_w_reg[0] != '0, m_w_reg[1] != '0,
            m_w_reg[2] != '0, m_w_reg[3] != '0, m_w_reg[4] != '0, m_w_reg[5] != '0}))
        else $error("underflow result not one-hot");

endmodule
`default_nettype wire

// ===== sim/fuzzy_membership_kernel_tb.sv =====
// Self-checking testbench of the fuzzy membership kernel: stream, APB registers, predictor.
`default_nettype none
module fuzzy_membership_kernel_tb;
    import fmk_pkg::*;

    localparam int LATENCY = 53;

    // Exponent table, exp(-2^j) in Q0.32 for j = -16 .. 3
    localparam logic [31:0] EXP_NEG [20] = '{
        32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
        32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
        32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
    };

    typedef struct packed {
        logic [5:0][15:0] weight;
        logic             underflow;
    } membership_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_voxel_value = '0;
    logic [15:0] s_bias_gain = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_weight_0, m_weight_1, m_weight_2, m_weight_3, m_weight_4, m_weight_5;
    logic        m_all_underflow;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fuzzy_membership_kernel i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_voxel_value(s_voxel_value), .s_bias_gain(s_bias_gain),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_weight_0(m_weight_0), .m_weight_1(m_weight_1), .m_weight_2(m_weight_2),
        .m_weight_3(m_weight_3), .m_weight_4(m_weight_4), .m_weight_5(m_weight_5),
        .m_all_underflow(m_all_underflow),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow copy of the register file
    logic [2:0]       model_count;
    logic [15:0]      model_spread;
    logic [5:0][15:0] model_center;

    membership_t expected_weights[$];
    int          error_count = 0;
    bit          idle_enable = 1'b1;
    int          results_seen = 0;
    int          stall_left = 0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0d, expected %0d (result %0d)",
                 what, got, want, results_seen);
        error_count++;
    endtask

    // Gaussian affinity d in Q1.32
    function automatic logic [32:0] gauss_affinity(input logic [17:0] y, input logic [15:0] c);
        logic [17:0] diff;
        logic [63:0] sq, t, d;
        diff = (y >= c) ? y - c : c - y;
        sq = 64'(diff) * diff;
        t = (sq * model_spread + (64'd1 << 23)) >> 24;
        if (t >= (64'd1 << 20)) return '0;
        d = 64'd1 << 32;
        for (int j = 0; j < 20; j++)
            if (t[j]) d = (d * EXP_NEG[j] + (64'd1 << 31)) >> 32;
        return d[32:0];
    endfunction

    function automatic membership_t predict_membership(input logic [15:0] x,
                                                       input logic [15:0] g);
        membership_t r;
        logic [17:0] y;
        logic [63:0] d[6];
        logic [63:0] sum, m, w;
        int n;
        y = 18'((64'(x) * g + 64'd8192) >> 14);
        n = model_count;
        if (n < 2) n = 2;
        if (n > 6) n = 6;
        sum = 0;
        r = '0;
        for (int i = 0; i < 6; i++) begin
            d[i] = (i < n) ? 64'(gauss_affinity(y, model_center[i])) : 64'd0;
            sum += d[i];
        end
        if (sum == 0) begin
            r.weight[n-1] = 16'hFFFF;
            r.underflow = 1'b1;
            return r;
        end
        for (int i = 0; i < n; i++) begin
            m = ((d[i] << 24) + (sum >> 1)) / sum;
            w = (m * m + (64'd1 << 31)) >> 32;
            r.weight[i] = (w > 64'hFFFF) ? 16'hFFFF : w[15:0];
        end
        return r;
    endfunction

    // Input side gap: valid drops for the length of the burst
    task automatic random_idle();
        if (idle_enable && $urandom_range(3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    // One voxel transaction; valid held until accepted
    task automatic send_voxel(input logic [15:0] x, input logic [15:0] g);
        random_idle();
        s_valid <= 1'b1;
        s_voxel_value <= x;
        s_bias_gain <= g;
        do @(posedge aclk); while (!s_ready);
        expected_weights = {expected_weights, predict_membership(x, g)};
        @(negedge aclk);
    endtask

    task automatic write_reg(input int idx, input logic [15:0] value);
        paddr <= ADDR_W'(4 * idx);
        pwdata <= 32'(value);
        pwrite <= 1'b1;
        psel <= 1'b1;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        case (idx)
            REG_CLASS_COUNT: model_count = value[2:0];
            REG_SPREAD:      model_spread = value;
            default:         model_center[idx - REG_CENTER_0] = value;
        endcase
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_weights.size() != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
    endtask

    // Result side: random m_ready stall bursts while idle_enable is set
    always @(negedge aclk) begin
        if (!aresetn || (idle_enable && stall_left > 0)) begin
            m_ready <= 1'b0;
            if (stall_left > 0) stall_left--;
        end else if (idle_enable && $urandom_range(7) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(5);
        end else begin
            m_ready <= 1'b1;
            stall_left = 0;
        end
    end

    always @(posedge aclk) begin
        membership_t want;
        logic [5:0][15:0] got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_weight_5, m_weight_4, m_weight_3, m_weight_2, m_weight_1, m_weight_0};
            if (expected_weights.size() == 0) begin
                report_mismatch("unexpected result transaction", '0, '0);
            end else begin
                want = expected_weights.pop_front();
                for (int i = 0; i < 6; i++)
                    if (got[i] !== want.weight[i])
                        report_mismatch($sformatf("weight_%0d", i), got[i], want.weight[i]);
                if (m_all_underflow !== want.underflow)
                    report_mismatch("all_underflow", 16'(m_all_underflow), 16'(want.underflow));
            end
            results_seen++;
        end
    end

    task automatic load_config(input int n, input logic [15:0] k,
                               input logic [5:0][15:0] c);
        write_reg(REG_CLASS_COUNT, 16'(n));
        write_reg(REG_SPREAD, k);
        for (int i = 0; i < 6; i++) write_reg(REG_CENTER_0 + i, c[i]);
    endtask

    // Directed: field extremes, unity gain, underflow, out-of-range counts
    task automatic test_directed();
        send_voxel(16'h0000, 16'h0000);
        send_voxel(16'hFFFF, 16'hFFFF);
        send_voxel(16'hFFFF, 16'h4000);
        send_voxel(16'h4000, 16'h4000);
        send_voxel(16'h8000, 16'h4000);
        send_voxel(16'h2000, 16'h4000);
        send_voxel(16'hFFFF, 16'h0000);
        send_voxel(16'h0000, 16'hFFFF);
        wait_drained();
        // far-away centers and max spread: every affinity underflows
        load_config(6, 16'hFFFF, {6{16'hFFFF}});
        send_voxel(16'h0000, 16'h4000);
        send_voxel(16'h1234, 16'h2000);
        wait_drained();
        load_config(0, 16'h0000, {16'd0, 16'd1000, 16'd20000, 16'd40000, 16'd60000, 16'hFFFF});
        send_voxel(16'h7FFF, 16'h4000);
        send_voxel(16'hFFFF, 16'hFFFF);
        wait_drained();
        write_reg(REG_CLASS_COUNT, 16'd1);
        send_voxel(16'h5555, 16'h4000);
        wait_drained();
        write_reg(REG_CLASS_COUNT, 16'd7);
        write_reg(REG_SPREAD, 16'd1);
        send_voxel(16'hAAAA, 16'h4000);
        send_voxel(16'h0001, 16'h8000);
        wait_drained();
    endtask

    // Random settings per phase, mostly near-unity gain, some random gain
    task automatic test_random(input int phases, input int per_phase);
        logic [5:0][15:0] c;
        logic [15:0] k;
        for (int p = 0; p < phases; p++) begin
            for (int i = 0; i < 6; i++) c[i] = 16'($urandom);
            case ($urandom_range(3))
                0: k = 16'($urandom);
                1: k = 16'($urandom_range(0, 255));
                default: k = 16'($urandom_range(256, 16384));
            endcase
            load_config($urandom_range(0, 7), k, c);
            for (int i = 0; i < per_phase; i++)
                send_voxel(16'($urandom),
                           ($urandom_range(3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(12000, 20000)));
            // sender holds off until all results are back
            wait_drained();
        end
    endtask

    initial begin
        model_count = 3'd3;
        model_spread = 16'd16384;
        model_center = {16'd0, 16'd0, 16'd49152, 16'd32768, 16'd16384, 16'd0};
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random(12, 70);
        idle_enable = 1'b0;
        test_random(2, 80);
        if (error_count == 0)
            $display("fuzzy_membership_kernel_tb: clean");
        else
            $display("fuzzy_membership_kernel_tb: errors");
        $finish;
    end

    initial begin
        #400000;
        $display("fuzzy_membership_kernel_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/fmk_pkg.sv
rtl/fmk_cfg.sv
rtl/fmk_affinity.sv
rtl/fmk_norm.sv
rtl/fuzzy_membership_kernel.sv
sim/fuzzy_membership_kernel_tb.sv
